// ----- sv/pngse_pkg.sv -----
// types, constants and control program of the stored-deflate png encoder
package pngse_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [6:0] t_pc;

    // configuration port
    localparam int C_CFG_IDX_W  = 1;
    localparam int C_CFG_DATA_W = 14;
    localparam logic [C_CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [C_CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [13:0] C_MAX_WIDTH = 14'd16383;
    localparam logic [31:0] C_CRC_POLY  = 32'hEDB88320;
    localparam logic [16:0] C_ADLER_MOD = 17'd65521;

    // byte source of one step
    typedef enum logic [3:0] {
        SRC_CONST,
        SRC_WIDTH,
        SRC_HEIGHT,
        SRC_CRC,
        SRC_IDAT,
        SRC_ADLER,
        SRC_FINAL,
        SRC_LEN,
        SRC_PIXEL,
        SRC_INPUT
    } t_src;

    // checksum update of one step
    typedef enum logic [1:0] {
        ADL_NONE,
        ADL_ROW,
        ADL_PIXEL
    } t_adl;

    // last-of-run marking
    typedef enum logic [1:0] {
        LR_NONE,
        LR_ALWAYS,
        LR_NOT_PENDING,
        LR_NOT_ROW_END
    } t_lr;

    // sequencing
    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_GOTO,
        JMP_SKIP_PEND,
        JMP_PIXEL
    } t_jmp;

    typedef struct packed {
        t_src  src;
        t_byte arg;
        logic  emit;
        logic  wait_in;
        logic  start;
        logic  crc_en;
        logic  crc_init;
        t_adl  adl;
        t_lr   lr;
        logic  eof;
        t_jmp  jmp;
        t_pc   target;
    } t_cw;

    typedef struct packed {
        t_cw  cw;
        logic fire;
    } t_ctrl;

    typedef struct packed {
        logic out_space;
        logic row_end;
        logic last_row;
        logic pending;
    } t_stat;

    // program addresses
    localparam t_pc A_IDLE   = 7'd0;
    localparam t_pc A_SIG    = 7'd1;
    localparam t_pc A_IHLEN  = 7'd9;
    localparam t_pc A_IHTAG  = 7'd13;
    localparam t_pc A_W      = 7'd17;
    localparam t_pc A_H      = 7'd21;
    localparam t_pc A_IHTAIL = 7'd25;
    localparam t_pc A_IHCRC  = 7'd30;
    localparam t_pc A_IDLEN  = 7'd34;
    localparam t_pc A_IDTAG  = 7'd38;
    localparam t_pc A_ROW    = 7'd44;
    localparam t_pc A_FILT   = 7'd49;
    localparam t_pc A_PIXR   = 7'd50;
    localparam t_pc A_PIXI   = 7'd51;
    localparam t_pc A_ADLER  = 7'd52;
    localparam t_pc A_CRC    = 7'd56;
    localparam t_pc A_IEND   = 7'd60;
    localparam t_pc A_LAST   = 7'd71;

    localparam t_byte C_SIG [8] = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
    localparam t_byte C_IHDR_LEN [4] = '{8'h00, 8'h00, 8'h00, 8'h0D};
    localparam t_byte C_IHDR_TAG [4] = '{8'h49, 8'h48, 8'h44, 8'h52};
    localparam t_byte C_IHDR_TAIL [5] = '{8'h08, 8'h06, 8'h00, 8'h00, 8'h00};
    localparam t_byte C_IDAT_TAG [6] = '{8'h49, 8'h44, 8'h41, 8'h54, 8'h08, 8'h1D};
    localparam t_byte C_IEND [12] = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h49, 8'h45,
                                      8'h4E, 8'h44, 8'hAE, 8'h42, 8'h60, 8'h82};

    // control store: one control word per step
    function automatic t_cw f_ucode(input t_pc a);
        t_cw cw;
        cw        = '0;
        cw.src    = SRC_CONST;
        cw.adl    = ADL_NONE;
        cw.lr     = LR_NONE;
        cw.jmp    = JMP_NEXT;
        cw.target = A_IDLE;
        cw.emit   = 1'b1;
        priority if (a == A_IDLE) begin
            cw.emit    = 1'b0;
            cw.wait_in = 1'b1;
            cw.start   = 1'b1;
        end else if (a < A_IHLEN) begin
            cw.arg = C_SIG[3'(a - A_SIG)];
        end else if (a < A_IHTAG) begin
            cw.arg      = C_IHDR_LEN[2'(a - A_IHLEN)];
            cw.crc_init = (a == A_IHTAG - 7'd1);
        end else if (a < A_W) begin
            cw.arg    = C_IHDR_TAG[2'(a - A_IHTAG)];
            cw.crc_en = 1'b1;
        end else if (a < A_H) begin
            cw.src    = SRC_WIDTH;
            cw.arg    = {6'b0, 2'(A_H - 7'd1 - a)};
            cw.crc_en = 1'b1;
        end else if (a < A_IHTAIL) begin
            cw.src    = SRC_HEIGHT;
            cw.arg    = {6'b0, 2'(A_IHTAIL - 7'd1 - a)};
            cw.crc_en = 1'b1;
        end else if (a < A_IHCRC) begin
            cw.arg    = C_IHDR_TAIL[3'(a - A_IHTAIL)];
            cw.crc_en = 1'b1;
        end else if (a < A_IDLEN) begin
            cw.src = SRC_CRC;
            cw.arg = {6'b0, 2'(A_IDLEN - 7'd1 - a)};
        end else if (a < A_IDTAG) begin
            cw.src      = SRC_IDAT;
            cw.arg      = {6'b0, 2'(A_IDTAG - 7'd1 - a)};
            cw.crc_init = (a == A_IDTAG - 7'd1);
        end else if (a < A_ROW) begin
            cw.arg    = C_IDAT_TAG[3'(a - A_IDTAG)];
            cw.crc_en = 1'b1;
        end else if (a == A_ROW) begin
            cw.src    = SRC_FINAL;
            cw.crc_en = 1'b1;
        end else if (a < A_FILT) begin
            cw.src    = SRC_LEN;
            cw.arg    = {6'b0, 2'(a - A_ROW - 7'd1)};
            cw.crc_en = 1'b1;
        end else if (a == A_FILT) begin
            cw.arg    = 8'h00;
            cw.crc_en = 1'b1;
            cw.adl    = ADL_ROW;
            cw.lr     = LR_NOT_PENDING;
            cw.jmp    = JMP_SKIP_PEND;
            cw.target = A_PIXI;
        end else if (a == A_PIXR) begin
            cw.src    = SRC_PIXEL;
            cw.crc_en = 1'b1;
            cw.adl    = ADL_PIXEL;
            cw.lr     = LR_NOT_ROW_END;
            cw.jmp    = JMP_PIXEL;
        end else if (a == A_PIXI) begin
            cw.src     = SRC_INPUT;
            cw.wait_in = 1'b1;
            cw.crc_en  = 1'b1;
            cw.adl     = ADL_PIXEL;
            cw.lr      = LR_NOT_ROW_END;
            cw.jmp     = JMP_PIXEL;
        end else if (a < A_CRC) begin
            cw.src    = SRC_ADLER;
            cw.arg    = {6'b0, 2'(A_CRC - 7'd1 - a)};
            cw.crc_en = 1'b1;
        end else if (a < A_IEND) begin
            cw.src = SRC_CRC;
            cw.arg = {6'b0, 2'(A_IEND - 7'd1 - a)};
        end else if (a < A_LAST) begin
            cw.arg = C_IEND[4'(a - A_IEND)];
        end else if (a == A_LAST) begin
            cw.arg      = C_IEND[11];
            cw.eof      = 1'b1;
            cw.lr       = LR_ALWAYS;
            cw.crc_init = 1'b1;
            cw.jmp      = JMP_GOTO;
            cw.target   = A_IDLE;
        end else begin
            cw.emit = 1'b0;
            cw.jmp  = JMP_GOTO;
        end
        return cw;
    endfunction

endpackage

// ----- sv/pngse_pixel_if.sv -----
// pixel byte channel
interface pngse_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;

    modport source (output valid, output pixel_byte, input ready);
    modport sink   (input valid, input pixel_byte, output ready);
endinterface

// ----- sv/pngse_png_if.sv -----
// png stream byte channel
interface pngse_png_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_file;

    modport source (output valid, output out_byte, output last_of_run, output end_of_file,
                    input ready);
    modport sink   (input valid, input out_byte, input last_of_run, input end_of_file,
                    output ready);
endinterface

// ----- sv/pngse_seq.sv -----
// microprogram sequencer: step counter, control store and jumps
module pngse_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pngse_pkg::t_stat i_stat,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output pngse_pkg::t_ctrl o_ctrl
);
    import pngse_pkg::*;

    t_pc  r_pc;
    t_pc  n_pc;
    t_cw  cw;
    logic go;

    always_comb begin
        cw = f_ucode(r_pc);
        go = (!cw.emit || i_stat.out_space) && (!cw.wait_in || i_in_valid);
        o_in_ready  = cw.wait_in && (!cw.emit || i_stat.out_space);
        o_ctrl.cw   = cw;
        o_ctrl.fire = go;
        n_pc = r_pc;
        if (go) begin
            unique case (cw.jmp)
                JMP_NEXT:      n_pc = r_pc + 7'd1;
                JMP_GOTO:      n_pc = cw.target;
                JMP_SKIP_PEND: n_pc = i_stat.pending ? r_pc + 7'd1 : cw.target;
                JMP_PIXEL: begin
                    priority if (!i_stat.row_end) n_pc = A_PIXI;
                    else if (i_stat.last_row)     n_pc = A_ADLER;
                    else                          n_pc = A_ROW;
                end
                default:       n_pc = A_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= A_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= A_LAST)
        else $error("step counter left the program");

    a_ready_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_pc == A_IDLE || r_pc == A_PIXI))
        else $error("pixel taken outside a pixel step");

endmodule

// ----- sv/pngse_dp.sv -----
// datapath: byte select, crc-32, adler-32, row counters, config and output register
module pngse_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  pngse_pkg::t_ctrl                      i_ctrl,
    output pngse_pkg::t_stat                      o_stat,
    input  logic [7:0]                            i_pixel_byte,
    input  logic                                  i_cfg_we,
    input  logic [pngse_pkg::C_CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pngse_pkg::C_CFG_DATA_W-1:0]    i_cfg_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [7:0]                            o_out_byte,
    output logic                                  o_last_of_run,
    output logic                                  o_end_of_file
);
    import pngse_pkg::*;

    function automatic logic [31:0] f_crc8(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'b0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ C_CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    t_cw cw;

    logic [13:0] r_width;
    logic [13:0] r_height;
    logic        r_header_sent;
    logic        r_pending;
    logic [7:0]  r_pixel;
    logic [31:0] r_crc;
    logic [15:0] r_lo;
    logic [15:0] r_hi;
    logic [15:0] r_byte_in_row;
    logic [13:0] r_row;
    logic [30:0] r_prod;
    logic [31:0] r_idat;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic        r_out_eof;

    logic [13:0] w_eff;
    logic [13:0] h_eff;
    logic [15:0] row_len4;
    logic [15:0] len16;
    logic [16:0] w_term;
    logic        row_end;
    logic        last_row;
    logic        out_space;
    logic [31:0] word;
    logic [1:0]  lane;
    logic [7:0]  cur_byte;
    logic        cur_last;
    logic [16:0] lo_sum;
    logic [16:0] lo_mod;
    logic [15:0] hi_add;
    logic [16:0] hi_sum;
    logic [16:0] hi_mod;
    logic        accept;

    assign cw = i_ctrl.cw;

    always_comb begin
        w_eff = r_width;
        if (r_width == 14'd0)        w_eff = 14'd1;
        if (r_width > C_MAX_WIDTH)   w_eff = C_MAX_WIDTH;
        h_eff    = (r_height == 14'd0) ? 14'd1 : r_height;
        row_len4 = {w_eff, 2'b00};
        len16    = row_len4 + 16'd1;
        w_term   = {1'b0, row_len4} + 17'd6;
        row_end  = (r_byte_in_row == row_len4 - 16'd1);
        last_row = (r_row == h_eff - 14'd1);
        out_space = !r_out_valid || i_out_ready;
        accept    = i_ctrl.fire && cw.wait_in;
    end

    assign o_stat.out_space = out_space;
    assign o_stat.row_end   = row_end;
    assign o_stat.last_row  = last_row;
    assign o_stat.pending   = r_pending;

    // byte of the current step
    always_comb begin
        word = '0;
        lane = cw.arg[1:0];
        unique case (cw.src)
            SRC_CONST:  begin word = {24'b0, cw.arg};        lane = 2'd0; end
            SRC_WIDTH:  word = {18'b0, w_eff};
            SRC_HEIGHT: word = {18'b0, h_eff};
            SRC_CRC:    word = ~r_crc;
            SRC_IDAT:   word = r_idat;
            SRC_ADLER:  word = {r_hi, r_lo};
            SRC_FINAL:  begin word = {31'b0, last_row};      lane = 2'd0; end
            SRC_LEN:    word = {~len16, len16};
            SRC_PIXEL:  begin word = {24'b0, r_pixel};       lane = 2'd0; end
            SRC_INPUT:  begin word = {24'b0, i_pixel_byte};  lane = 2'd0; end
            default:    word = '0;
        endcase
        cur_byte = word[{lane, 3'b000} +: 8];
        unique case (cw.lr)
            LR_NONE:        cur_last = 1'b0;
            LR_ALWAYS:      cur_last = 1'b1;
            LR_NOT_PENDING: cur_last = !r_pending;
            LR_NOT_ROW_END: cur_last = !row_end;
            default:        cur_last = 1'b0;
        endcase
    end

    // adler-32: sums stay below the modulus, one subtract each
    always_comb begin
        lo_sum = {1'b0, r_lo} + {9'b0, cur_byte};
        lo_mod = (lo_sum >= C_ADLER_MOD) ? lo_sum - C_ADLER_MOD : lo_sum;
        hi_add = (cw.adl == ADL_PIXEL) ? lo_mod[15:0] : r_lo;
        hi_sum = {1'b0, r_hi} + {1'b0, hi_add};
        hi_mod = (hi_sum >= C_ADLER_MOD) ? hi_sum - C_ADLER_MOD : hi_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width       <= 14'd1;
            r_height      <= 14'd1;
            r_header_sent <= 1'b0;
            r_pending     <= 1'b0;
            r_byte_in_row <= '0;
            r_row         <= '0;
            r_crc         <= '1;
            r_lo          <= 16'd1;
            r_hi          <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we && !r_header_sent) begin
                if (i_cfg_idx == CFG_IMAGE_WIDTH)  r_width  <= i_cfg_data;
                if (i_cfg_idx == CFG_IMAGE_HEIGHT) r_height <= i_cfg_data;
            end
            if (i_ctrl.fire) begin
                if (cw.start) begin
                    r_header_sent <= 1'b1;
                    r_pending     <= 1'b1;
                    r_byte_in_row <= '0;
                    r_row         <= '0;
                    r_lo          <= 16'd1;
                    r_hi          <= '0;
                end
                if (cw.eof)                r_header_sent <= 1'b0;
                if (cw.src == SRC_PIXEL)   r_pending     <= 1'b0;
                if (cw.crc_init)           r_crc <= '1;
                else if (cw.crc_en)        r_crc <= f_crc8(r_crc, cur_byte);
                if (cw.adl == ADL_PIXEL) begin
                    r_lo <= lo_mod[15:0];
                    r_hi <= hi_mod[15:0];
                    if (row_end) begin
                        r_byte_in_row <= '0;
                        if (!last_row) r_row <= r_row + 14'd1;
                    end else begin
                        r_byte_in_row <= r_byte_in_row + 16'd1;
                    end
                end else if (cw.adl == ADL_ROW) begin
                    r_hi <= hi_mod[15:0];
                end
            end
            if (i_ctrl.fire && cw.emit) r_out_valid <= 1'b1;
            else if (i_out_ready)       r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && cw.start) r_pixel <= i_pixel_byte;
        if (i_ctrl.fire && cw.emit) begin
            r_out_byte <= cur_byte;
            r_out_last <= cur_last;
            r_out_eof  <= cw.eof;
        end
        // idat length, multiplier registered before the add
        r_prod <= w_term * h_eff;
        r_idat <= {1'b0, r_prod} + 32'd6;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;
    assign o_end_of_file = r_out_eof;

    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_end_of_file) |-> o_last_of_run)
        else $error("end of file byte not marked last of run");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_in_row < row_len4)
        else $error("byte counter ran past the row");

    a_one_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> !r_pending)
        else $error("pixel taken while first pixel still held");

endmodule

// ----- sv/png_stored_rgba_encoder.sv -----
// top level of the stored-deflate rgba png encoder
//
// channel   direction  payload                                   transaction
// i_pix     in         pixel_byte[7:0]                           valid && ready
// o_png     out        out_byte[7:0], last_of_run, end_of_file   valid && ready
// i_cfg_*   in         i_cfg_idx (0 width, 1 height), data[13:0] i_cfg_we
//
// one micro step per cycle unless the output is full or an input step waits for
// a pixel; each step emits at most one byte into a single output register, so a
// pixel byte is one step of the pixel loop; an image is 1 + 49 header steps (incl.
// first row header), 4*w*h pixel steps, 6 per further row header, 20 of trailer
// a stall on o_png freezes the step counter; the output register decouples
// the sides so the next step runs in the cycle the waiting byte is taken
// synchronous active-low reset puts the step counter at idle and the
// registers at width 1, height 1; no clearing pass is needed
module png_stored_rgba_encoder (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    pngse_pixel_if.sink                        i_pix,
    pngse_png_if.source                        o_png,
    input  logic                               i_cfg_we,
    input  logic [pngse_pkg::C_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pngse_pkg::C_CFG_DATA_W-1:0] i_cfg_data
);
    import pngse_pkg::*;

    // control word and step strobe from the sequencer
    t_ctrl ctrl;
    // row, pending-pixel and output-space flags back to the sequencer
    t_stat stat;

    // control store walks the file layout; jumps close the pixel loop,
    // branch to the next row header or to the trailer
    pngse_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stat     (stat),
        .i_in_valid (i_pix.valid),
        .o_in_ready (i_pix.ready),
        .o_ctrl     (ctrl)
    );

    // checksums, counters, config registers and the output register
    pngse_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .o_stat        (stat),
        .i_pixel_byte  (i_pix.pixel_byte),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_png.valid),
        .i_out_ready   (o_png.ready),
        .o_out_byte    (o_png.out_byte),
        .o_last_of_run (o_png.last_of_run),
        .o_end_of_file (o_png.end_of_file)
    );

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// self-checking bench for the stored-deflate rgba png encoder: directed rows, random images
module testbench;
    import pngse_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 10;
    localparam int IDLE_PCT     = 32;
    localparam int RANDOM_ITEMS = 96;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 64;
    localparam int MAX_REPORTS  = 10;
    localparam int N_DIRECTED   = 24;
    localparam int TIMEOUT_NS   = 20_000_000;

    localparam int unsigned ADLER_MOD = 65521;
    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;

    // fixed pieces of the png stream
    localparam logic [7:0] PNG_SIG [8]   = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                             8'h0D, 8'h0A, 8'h1A, 8'h0A};
    localparam logic [7:0] IHDR_TAG [4]  = '{8'h49, 8'h48, 8'h44, 8'h52};
    localparam logic [7:0] IHDR_TAIL [5] = '{8'h08, 8'h06, 8'h00, 8'h00, 8'h00};
    localparam logic [7:0] IDAT_HEAD [6] = '{8'h49, 8'h44, 8'h41, 8'h54, 8'h08, 8'h1D};
    localparam logic [7:0] IEND_CHUNK [12] = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h49, 8'h45,
                                               8'h4E, 8'h44, 8'hAE, 8'h42, 8'h60, 8'h82};

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       eof;
    } png_byte_t;

    // one directed pixel byte; fin/eof is the last byte of the run it causes
    typedef struct packed {
        logic        set_size;
        logic [13:0] width;
        logic [13:0] height;
        logic [7:0]  pix;
        logic [7:0]  fin;
        logic        eof;
    } directed_row_t;

    localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // 1x1 image at the reset size: extremes of the byte, trailer on the fourth
        '{1'b0, 14'd0, 14'd0, 8'h00, 8'h00, 1'b0},
        '{1'b0, 14'd0, 14'd0, 8'hFF, 8'hFF, 1'b0},
        '{1'b0, 14'd0, 14'd0, 8'h80, 8'h80, 1'b0},
        '{1'b0, 14'd0, 14'd0, 8'h7F, 8'h82, 1'b1},
        // zero width and height act as one
        '{1'b1, 14'd0, 14'd0, 8'hAA, 8'hAA, 1'b0},
        '{1'b0, 14'd0, 14'd0, 8'h55, 8'h55, 1'b0},
        '{1'b0, 14'd0, 14'd0, 8'h01, 8'h01, 1'b0},
        '{1'b0, 14'd0, 14'd0, 8'hFE, 8'h82, 1'b1},
        // 2x1: walking one through the pixel byte
        '{1'b1, 14'd2, 14'd1, 8'h01, 8'h01, 1'b0},
        '{1'b0, 14'd0, 14'd0, 8'h02, 8'h02, 1'b0},
        '{1'b0, 14'd0, 14'd0, 8'h04, 8'h04, 1'b0},
        '{1'b0, 14'd0, 14'd0, 8'h08, 8'h08, 1'b0},
        '{1'b0, 14'd0, 14'd0, 8'h10, 8'h10, 1'b0},
        '{1'b0, 14'd0, 14'd0, 8'h20, 8'h20, 1'b0},
        '{1'b0, 14'd0, 14'd0, 8'h40, 8'h40, 1'b0},
        '{1'b0, 14'd0, 14'd0, 8'h80, 8'h82, 1'b1},
        // 1x2: the first row ends in the next row header's filter byte
        '{1'b1, 14'd1, 14'd2, 8'hFF, 8'hFF, 1'b0},
        '{1'b0, 14'd0, 14'd0, 8'hFE, 8'hFE, 1'b0},
        '{1'b0, 14'd0, 14'd0, 8'hFD, 8'hFD, 1'b0},
        '{1'b0, 14'd0, 14'd0, 8'hFC, 8'h00, 1'b0},
        '{1'b0, 14'd0, 14'd0, 8'h00, 8'h00, 1'b0},
        '{1'b0, 14'd0, 14'd0, 8'h11, 8'h11, 1'b0},
        '{1'b0, 14'd0, 14'd0, 8'h22, 8'h22, 1'b0},
        '{1'b0, 14'd0, 14'd0, 8'h33, 8'h82, 1'b1}
    };

    logic                    i_clk   = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we;
    logic [C_CFG_IDX_W-1:0]  i_cfg_idx;
    logic [C_CFG_DATA_W-1:0] i_cfg_data;

    pngse_pixel_if pix_ch ();
    pngse_png_if   png_ch ();

    png_stored_rgba_encoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_ch),
        .o_png      (png_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // shared between stimulus and the png sink
    logic quiet         = 1'b0;  // no idling on either side
    int   hold_requests = 0;     // each bump asks the sink for one long hold-off

    int mismatch_count = 0;
    int bytes_checked  = 0;
    int runs_done      = 0;

    // ---------------------------------------------------------------
    // encoder prediction: own copy of the registers and checksums
    // ---------------------------------------------------------------
    logic [13:0]    size_w, size_h;
    logic [31:0]    crc_reg;
    int unsigned    adler_lo, adler_hi, row_byte, row_idx;
    logic           image_open;
    png_byte_t      png_stream_q [$];

    function automatic int unsigned used_width();
        // a zero register acts as one; 14 bits can never pass the maximum width
        if (size_w == '0) return 1;
        if (size_w > C_MAX_WIDTH) return C_MAX_WIDTH;
        return size_w;
    endfunction

    function automatic int unsigned used_height();
        return (size_h == '0) ? 1 : size_h;
    endfunction

    function automatic void reset_encoder_model();
        size_w     = 14'd1;
        size_h     = 14'd1;
        crc_reg    = '1;
        adler_lo   = 1;
        adler_hi   = 0;
        row_byte   = 0;
        row_idx    = 0;
        image_open = 1'b0;
        png_stream_q.delete();
    endfunction

    // reflected crc-32, one byte at a time
    function automatic void crc_feed(input logic [7:0] b);
        logic [31:0] c;
        c = crc_reg ^ {24'h0, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        crc_reg = c;
    endfunction

    function automatic void emit_byte(input logic [7:0] b, input logic with_crc);
        png_stream_q.push_back('{b, 1'b0, 1'b0});
        if (with_crc) crc_feed(b);
    endfunction

    function automatic void emit_be32(input logic [31:0] v, input logic with_crc);
        emit_byte(v[31:24], with_crc);
        emit_byte(v[23:16], with_crc);
        emit_byte(v[15:8], with_crc);
        emit_byte(v[7:0], with_crc);
    endfunction

    // stored block header of a row plus filter byte 0
    function automatic void emit_row_header();
        logic [31:0] len, nlen;
        len  = 4 * used_width() + 1;
        nlen = ~len & 32'hFFFF;
        emit_byte((row_idx + 1 >= used_height()) ? 8'h01 : 8'h00, 1'b1);
        emit_byte(len[7:0], 1'b1);
        emit_byte(len[15:8], 1'b1);
        emit_byte(nlen[7:0], 1'b1);
        emit_byte(nlen[15:8], 1'b1);
        emit_byte(8'h00, 1'b1);
        // a zero filter byte only moves the high sum
        adler_hi = (adler_hi + adler_lo) % ADLER_MOD;
    endfunction

    function automatic void emit_file_header();
        logic [31:0] w, h;
        w = used_width();
        h = used_height();
        for (int i = 0; i < 8; i++) emit_byte(PNG_SIG[i], 1'b0);
        emit_be32(32'd13, 1'b0);
        crc_reg = '1;
        for (int i = 0; i < 4; i++) emit_byte(IHDR_TAG[i], 1'b1);
        emit_be32(w, 1'b1);
        emit_be32(h, 1'b1);
        for (int i = 0; i < 5; i++) emit_byte(IHDR_TAIL[i], 1'b1);
        emit_be32(~crc_reg, 1'b0);
        emit_be32(6 + (6 + 4 * w) * h, 1'b0);
        crc_reg = '1;
        for (int i = 0; i < 6; i++) emit_byte(IDAT_HEAD[i], 1'b1);
        adler_lo = 1;
        adler_hi = 0;
        row_byte = 0;
        row_idx  = 0;
        emit_row_header();
        image_open = 1'b1;
    endfunction

    function automatic void emit_file_trailer();
        logic [31:0] adler;
        adler = {adler_hi[15:0], adler_lo[15:0]};
        emit_be32(adler, 1'b1);
        emit_be32(~crc_reg, 1'b0);
        for (int i = 0; i < 12; i++) emit_byte(IEND_CHUNK[i], 1'b0);
        png_stream_q[png_stream_q.size() - 1].eof = 1'b1;
        crc_reg    = '1;
        adler_lo   = 1;
        adler_hi   = 0;
        row_byte   = 0;
        row_idx    = 0;
        image_open = 1'b0;
    endfunction

    // expected stream bytes caused by one accepted pixel byte
    function automatic void encode_pixel(input logic [7:0] b);
        if (!image_open) emit_file_header();
        emit_byte(b, 1'b1);
        adler_lo = (adler_lo + b) % ADLER_MOD;
        adler_hi = (adler_hi + adler_lo) % ADLER_MOD;
        row_byte++;
        if (row_byte >= 4 * used_width()) begin
            row_byte = 0;
            if (row_idx + 1 >= used_height()) begin
                emit_file_trailer();
            end else begin
                row_idx = (row_idx + 1) & 32'h3FFF;
                emit_row_header();
            end
        end
        png_stream_q[png_stream_q.size() - 1].last = 1'b1;
    endfunction

    // size registers only move between images
    function automatic void write_size_reg(input logic [C_CFG_IDX_W-1:0] idx,
                                           input logic [C_CFG_DATA_W-1:0] value);
        if (!image_open) begin
            if (idx == CFG_IMAGE_WIDTH) size_w = value;
            else if (idx == CFG_IMAGE_HEIGHT) size_h = value;
        end
    endfunction

    function automatic void note_mismatch(input string what, input png_byte_t want,
                                          input png_byte_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s at stream byte %0d: expected %02h last %0b eof %0b, %s",
                     $time, what, bytes_checked, want.data, want.last, want.eof,
                     $sformatf("got %02h last %0b eof %0b", got.data, got.last, got.eof));
    endfunction

    // ---------------------------------------------------------------
    // checker: all sampling at the rising edge, outputs checked before
    // the same edge's pixel transaction is predicted
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : stream_check
        png_byte_t got, want;
        if (!i_rst_n) begin
            reset_encoder_model();
        end else begin
            if (png_ch.valid && png_ch.ready) begin
                got = '{png_ch.out_byte, png_ch.last_of_run, png_ch.end_of_file};
                if (png_stream_q.size() == 0) begin
                    note_mismatch("unexpected byte", '0, got);
                end else begin
                    want = png_stream_q.pop_front();
                    if (got.data !== want.data || got.last !== want.last
                            || got.eof !== want.eof)
                        note_mismatch("stream mismatch", want, got);
                end
                // directed rows also carry the hand-read end of their run
                if (got.last === 1'b1) begin
                    if (runs_done < N_DIRECTED) begin
                        want = '{DIRECTED_ROWS[runs_done].fin, 1'b1,
                                 DIRECTED_ROWS[runs_done].eof};
                        if (got.data !== want.data || got.eof !== want.eof)
                            note_mismatch("directed run end", want, got);
                    end
                    runs_done++;
                end
                bytes_checked++;
            end
            if (i_cfg_we) write_size_reg(i_cfg_idx, i_cfg_data);
            if (pix_ch.valid && pix_ch.ready) encode_pixel(pix_ch.pixel_byte);
        end
    end

    // ---------------------------------------------------------------
    // png sink: random back-pressure, long hold-offs on request
    // ---------------------------------------------------------------
    initial begin : png_sink
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        png_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left != 0) begin
                hold_left--;
                png_ch.ready <= 1'b0;
            end else if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
                png_ch.ready <= 1'b0;
            end else begin
                png_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // ---------------------------------------------------------------
    // pixel source
    // ---------------------------------------------------------------
    task automatic send_pixel(input logic [7:0] b);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            pix_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_ch.valid      <= 1'b1;
        pix_ch.pixel_byte <= b;
        do @(posedge i_clk); while (pix_ch.ready !== 1'b1);
    endtask

    // drop valid and let every expected byte arrive; the queue is read at the
    // falling edge so the outcome does not hang on process order
    task automatic wait_stream_drained();
        pix_ch.valid <= 1'b0;
        do @(negedge i_clk); while (png_stream_q.size() != 0);
        @(posedge i_clk);
    endtask

    // only called between images, once the stream is drained
    task automatic set_image_size(input logic [13:0] w, input logic [13:0] h);
        wait_stream_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IMAGE_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_IMAGE_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin : stimulus
        logic [13:0] w, h;
        int          n_bytes;
        int          img;
        int          random_items;

        pix_ch.valid      <= 1'b0;
        pix_ch.pixel_byte <= 8'h00;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= CFG_IMAGE_WIDTH;
        i_cfg_data        <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows: first image runs at the reset size
        foreach (DIRECTED_ROWS[r]) begin
            if (DIRECTED_ROWS[r].set_size)
                set_image_size(DIRECTED_ROWS[r].width, DIRECTED_ROWS[r].height);
            send_pixel(DIRECTED_ROWS[r].pix);
        end

        // random small images; the first three carry the stall scenarios
        img          = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS || img < 3) begin
            w = 14'($urandom_range(0, 5));
            h = 14'($urandom_range(0, 3));
            if (img == 0 || img == 1) begin
                w = 14'd3;
                h = 14'd2;
            end
            set_image_size(w, h);
            n_bytes = 4 * ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
            // long sink hold while pixels keep coming, so the input backs up
            if (img == 0) hold_requests++;
            quiet = (img == 1);
            for (int i = 0; i < n_bytes; i++) begin
                // source pauses mid-image until the stream has caught up
                if (img == 2 && i == 2) wait_stream_drained();
                send_pixel(8'($urandom_range(255)));
            end
            quiet = 1'b0;
            random_items += n_bytes;
            img++;
        end

        wait_stream_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        // anything still expected never showed up
        mismatch_count += png_stream_q.size();
        if (mismatch_count == 0)
            $display("** png_stored_rgba_encoder: PASSED **");
        else
            $display("** png_stored_rgba_encoder: FAILED **");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("** png_stored_rgba_encoder: FAILED **");
        $finish;
    end

endmodule
